@@ hw/rtl/qpn_pkg.sv @@
package qpn_pkg;

  localparam int COUNT_WIDTH = 32;
  localparam int PAGE_LIMIT  = 16;
  localparam int OUT_WIDTH   = 32;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 104;

  typedef logic [COUNT_WIDTH-1:0] count_t;

  localparam logic [15:0] LOCKOUT_RST = 16'd180;
  localparam logic [3:0]  DETENT_RST  = 4'd4;
  localparam logic [4:0]  PAGES_RST   = 5'd3;

  typedef enum logic [1:0] {
    CFG_LOCKOUT = 2'd0,
    CFG_DETENT  = 2'd1,
    CFG_PAGES   = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    DET_NONE = 2'd0,
    DET_FWD  = 2'd1,
    DET_BACK = 2'd2
  } det_ev_t;

  typedef enum logic [1:0] {
    BTN_NONE    = 2'd0,
    BTN_BACK    = 2'd1,
    BTN_CONFIRM = 2'd2
  } btn_ev_t;

  typedef struct packed {
    logic [15:0] lockout_ms;
    logic [3:0]  detent_steps;
    logic [4:0]  page_count;
  } qpn_cfg_t;

  typedef struct packed {
    logic               have_prev;
    logic [1:0]         prev_ab;
    logic signed [4:0]  step_accum;
    count_t             position;
    logic [3:0]         page;
    count_t             back_count;
    count_t             confirm_count;
    logic [31:0]        last_press_ms;
  } qpn_state_t;

  typedef struct packed {
    det_ev_t detent_event;
    btn_ev_t button_event;
  } qpn_events_t;

  // quadrature transition value, code is {prev_ab, ab}
  function automatic logic signed [1:0] quad_step(input logic [3:0] code);
    logic signed [1:0] r;
    case (code) inside
      4'b0001, 4'b0111, 4'b1000, 4'b1110: r = -2'sd1;
      4'b0010, 4'b0100, 4'b1011, 4'b1101: r = 2'sd1;
      default:                            r = 2'sd0;
    endcase
    return r;
  endfunction

  // one page step with wrap, cnt already clamped to 1..16
  function automatic logic [3:0] move_page(input logic [3:0] idx, input logic up,
                                           input logic [4:0] cnt);
    logic signed [5:0] np;
    logic [3:0]        r;
    np = up ? ($signed({2'b00, idx}) + 6'sd1) : ($signed({2'b00, idx}) - 6'sd1);
    if (np < 6'sd0) begin
      r = 4'(cnt - 5'd1);
    end else if (np >= $signed({1'b0, cnt})) begin
      r = 4'd0;
    end else begin
      r = np[3:0];
    end
    return r;
  endfunction

  function automatic logic [OUT_WIDTH-1:0] fit_out(input count_t v);
    logic [63:0] t;
    t = 64'(v);
    return t[OUT_WIDTH-1:0];
  endfunction

endpackage

@@ hw/rtl/quadrature_page_navigator.sv @@
// channel | dir | signals                        | payload
// in      | in  | in_tvalid in_tready in_tdata   | encoder levels, buttons, timestamp
// out     | out | out_tvalid out_tready out_tdata| position, page, press counts, events
// cfg     | in  | cfg_we cfg_addr cfg_wdata      | 0 lockout_ms, 1 detent_steps, 2 page_count
//
// one item per clock while the output drains; the result appears in the cycle after the item is taken
// the whole update is one combinational pass from the state registers into
// the state and result registers
// the result register frees itself in the cycle it is taken, so in_tready
// stays high under a continuously draining output
// synchronous active-low reset clears state and restores register defaults
module quadrature_page_navigator import qpn_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [0] enc_a, [1] enc_b, [2] back_n, [3] confirm_n, [35:4] now_ms, [39:36] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [31:0] position, [35:32] page, [67:36] back_presses, [99:68] confirm_presses,
  // [101:100] detent_event, [103:102] button_event
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [1:0]             cfg_addr,
  input  logic [15:0]            cfg_wdata
);

  qpn_cfg_t    cfg_r;
  qpn_state_t  state_r;
  qpn_state_t  state_nxt;
  qpn_events_t ev;
  logic        out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TDATA_W-1:0] out_data_nxt;
  logic        in_fire;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  qpn_step u_step (
    .st        (state_r),
    .cfg       (cfg_r),
    .enc_a     (in_tdata[0]),
    .enc_b     (in_tdata[1]),
    .back_n    (in_tdata[2]),
    .confirm_n (in_tdata[3]),
    .now_ms    (in_tdata[35:4]),
    .st_nxt    (state_nxt),
    .ev        (ev)
  );

  assign out_data_nxt = {ev.button_event, ev.detent_event,
                         fit_out(state_nxt.confirm_count),
                         fit_out(state_nxt.back_count),
                         state_nxt.page,
                         fit_out(state_nxt.position)};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lockout_ms   <= LOCKOUT_RST;
      cfg_r.detent_steps <= DETENT_RST;
      cfg_r.page_count   <= PAGES_RST;
      state_r            <= '0;
      out_valid_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_LOCKOUT: cfg_r.lockout_ms   <= cfg_wdata;
          CFG_DETENT:  cfg_r.detent_steps <= cfg_wdata[3:0];
          CFG_PAGES:   cfg_r.page_count   <= cfg_wdata[4:0];
          default: ;
        endcase
      end
      if (in_fire) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= out_data_nxt;
    end
  end

  // every taken item yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_tvalid)
    else $error("no result after a taken item");

  // position moves exactly when a detent is reported
  a_detent_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && $past(rst_n)) |=>
      ((out_data_r[101:100] != DET_NONE) == (state_r.position != $past(state_r.position))))
    else $error("position change and detent event disagree");

  // back counter moves exactly when a back press is reported
  a_back_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && $past(rst_n)) |=>
      ((out_data_r[103:102] == BTN_BACK) == (state_r.back_count != $past(state_r.back_count))))
    else $error("back count change and button event disagree");

  // state only moves on a taken item
  a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_fire && $past(rst_n)) |=> $stable(state_r))
    else $error("state changed without an item");

  // once the first sample is latched the flag stays set until reset
  a_prev_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.have_prev |=> state_r.have_prev)
    else $error("first-sample flag dropped");

endmodule

@@ hw/rtl/qpn_step.sv @@
module qpn_step import qpn_pkg::*; (
  input  qpn_state_t  st,
  input  qpn_cfg_t    cfg,
  input  logic        enc_a,
  input  logic        enc_b,
  input  logic        back_n,
  input  logic        confirm_n,
  input  logic [31:0] now_ms,
  output qpn_state_t  st_nxt,
  output qpn_events_t ev
);

  logic [1:0]        ab;
  logic [3:0]        thr;
  logic signed [4:0] thr_s;
  logic [4:0]        cnt;
  logic signed [1:0] q;
  logic signed [4:0] acc_sum;
  logic [31:0]       elapsed;

  assign ab      = {enc_a, enc_b};
  assign thr     = (cfg.detent_steps == 4'd0) ? 4'd1 : cfg.detent_steps;
  assign thr_s   = $signed({1'b0, thr});
  assign cnt     = (cfg.page_count == 5'd0) ? 5'd1 :
                   (cfg.page_count > 5'(PAGE_LIMIT)) ? 5'(PAGE_LIMIT) : cfg.page_count;
  assign q       = quad_step({st.prev_ab, ab});
  assign acc_sum = st.step_accum + {{3{q[1]}}, q};
  assign elapsed = now_ms - st.last_press_ms;

  always_comb begin
    st_nxt          = st;
    ev.detent_event = DET_NONE;
    ev.button_event = BTN_NONE;

    if (!st.have_prev) begin
      st_nxt.have_prev = 1'b1;
      st_nxt.prev_ab   = ab;
    end else if (ab != st.prev_ab) begin
      st_nxt.prev_ab    = ab;
      st_nxt.step_accum = acc_sum;
      if (acc_sum >= thr_s) begin
        st_nxt.position   = st.position + 1'b1;
        st_nxt.page       = move_page(st.page, 1'b1, cnt);
        st_nxt.step_accum = 5'sd0;
        ev.detent_event   = DET_FWD;
      end else if (acc_sum <= -thr_s) begin
        st_nxt.position   = st.position - 1'b1;
        st_nxt.page       = move_page(st.page, 1'b0, cnt);
        st_nxt.step_accum = 5'sd0;
        ev.detent_event   = DET_BACK;
      end
    end

    // buttons see the page after any detent in the same item
    if (elapsed >= {16'd0, cfg.lockout_ms}) begin
      if (!back_n) begin
        st_nxt.back_count    = st.back_count + 1'b1;
        st_nxt.page          = move_page(st_nxt.page, 1'b0, cnt);
        st_nxt.last_press_ms = now_ms;
        ev.button_event      = BTN_BACK;
      end else if (!confirm_n) begin
        st_nxt.confirm_count = st.confirm_count + 1'b1;
        st_nxt.page          = move_page(st_nxt.page, 1'b1, cnt);
        st_nxt.last_press_ms = now_ms;
        ev.button_event      = BTN_CONFIRM;
      end
    end
  end

endmodule

@@ bench/quadrature_page_navigator_test.sv @@
`timescale 1ns / 1ps

module quadrature_page_navigator_test;
  import qpn_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int REPORT_LIMIT   = 10;

  // transition value indexed by {previous ab, new ab}
  localparam int QUAD_DELTA [0:15] = '{0, -1, 1, 0, 1, 0, 0, -1, -1, 0, 0, 1, 0, 1, -1, 0};
  localparam logic [1:0] GRAY_WALK [0:3] = '{2'b00, 2'b01, 2'b11, 2'b10};

  typedef struct packed {
    logic [3:0]  pad;
    logic [31:0] now_ms;
    logic        confirm_n;
    logic        back_n;
    logic        enc_b;
    logic        enc_a;
  } sample_t;

  typedef struct packed {
    btn_ev_t     button_event;
    det_ev_t     detent_event;
    logic [31:0] confirm_presses;
    logic [31:0] back_presses;
    logic [3:0]  page;
    logic [31:0] position;
  } readout_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_addr = '0;
  logic [15:0] cfg_wdata = '0;

  sample_t  sample_backlog[$];
  readout_t predicted_readouts[$];
  int sender_idle_pct = 0;
  int recv_stall_pct = 0;
  int error_count = 0;
  int idle_cycles = 0;

  // navigator copy of registers and state
  logic [15:0] nav_lockout = LOCKOUT_RST;
  logic [3:0]  nav_detent = DETENT_RST;
  logic [4:0]  nav_pages = PAGES_RST;
  logic        nav_have_prev = 1'b0;
  logic [1:0]  nav_prev_ab = 2'b00;
  int          nav_accum = 0;
  logic [31:0] nav_position = '0;
  logic [3:0]  nav_page = '0;
  logic [31:0] nav_backs = '0;
  logic [31:0] nav_confirms = '0;
  logic [31:0] nav_last_press = '0;

  // stimulus walk
  int          walk_pos = 0;
  int          walk_dir = 1;
  logic [31:0] walk_now = '0;

  quadrature_page_navigator dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [3:0] shift_page(logic [3:0] idx, int delta);
    int cnt;
    int np;
    cnt = (nav_pages == 0) ? 1 : ((nav_pages > 16) ? 16 : int'(nav_pages));
    np = int'(idx) + delta;
    if (np < 0) begin
      np = cnt - 1;
    end else if (np >= cnt) begin
      np = 0;
    end
    return 4'(np);
  endfunction

  function automatic readout_t advance_navigator(sample_t s);
    readout_t r;
    logic [1:0] ab;
    logic [31:0] since;
    int thr;
    ab = {s.enc_a, s.enc_b};
    r.detent_event = DET_NONE;
    r.button_event = BTN_NONE;
    thr = (nav_detent == 0) ? 1 : int'(nav_detent);
    if (!nav_have_prev) begin
      nav_have_prev = 1'b1;
      nav_prev_ab = ab;
    end else if (ab != nav_prev_ab) begin
      nav_accum += QUAD_DELTA[{nav_prev_ab, ab}];
      nav_prev_ab = ab;
      if (nav_accum >= thr) begin
        nav_position = nav_position + 32'd1;
        nav_page = shift_page(nav_page, 1);
        nav_accum = 0;
        r.detent_event = DET_FWD;
      end else if (nav_accum <= -thr) begin
        nav_position = nav_position - 32'd1;
        nav_page = shift_page(nav_page, -1);
        nav_accum = 0;
        r.detent_event = DET_BACK;
      end
    end
    since = s.now_ms - nav_last_press;
    if (since >= {16'd0, nav_lockout}) begin
      if (!s.back_n) begin
        nav_backs = nav_backs + 32'd1;
        nav_page = shift_page(nav_page, -1);
        nav_last_press = s.now_ms;
        r.button_event = BTN_BACK;
      end else if (!s.confirm_n) begin
        nav_confirms = nav_confirms + 32'd1;
        nav_page = shift_page(nav_page, 1);
        nav_last_press = s.now_ms;
        r.button_event = BTN_CONFIRM;
      end
    end
    r.position = nav_position;
    r.page = nav_page;
    r.back_presses = nav_backs;
    r.confirm_presses = nav_confirms;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      error_count++;
      if (error_count <= REPORT_LIMIT) begin
        $display("mismatch in %s: expected %0h, got %0h", name, want, got);
      end
    end
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (sample_backlog.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tdata <= sample_backlog.pop_front();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : monitor
    readout_t want;
    readout_t got;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = readout_t'(out_tdata);
        if (predicted_readouts.size() == 0) begin
          error_count++;
          if (error_count <= REPORT_LIMIT) begin
            $display("unexpected result item %0h", out_tdata);
          end
        end else begin
          want = predicted_readouts.pop_front();
          check_field("position", want.position, got.position);
          check_field("page", 32'(want.page), 32'(got.page));
          check_field("back_presses", want.back_presses, got.back_presses);
          check_field("confirm_presses", want.confirm_presses, got.confirm_presses);
          check_field("detent_event", 32'(want.detent_event), 32'(got.detent_event));
          check_field("button_event", 32'(want.button_event), 32'(got.button_event));
        end
      end
      if (in_tvalid && in_tready) begin
        predicted_readouts.push_back(advance_navigator(sample_t'(in_tdata)));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic queue_sample(bit a, bit b, bit bk_n, bit cf_n, logic [31:0] now);
    sample_t s;
    s.pad = '0;
    s.now_ms = now;
    s.confirm_n = cf_n;
    s.back_n = bk_n;
    s.enc_b = b;
    s.enc_a = a;
    sample_backlog.push_back(s);
  endtask

  // mostly clean quadrature walks with rising time, plus glitches and time jumps
  task automatic queue_random(int count);
    int sel;
    logic [1:0] ab;
    bit bk_n;
    bit cf_n;
    for (int i = 0; i < count; i++) begin
      sel = $urandom_range(99);
      if (sel < 60) begin
        if ($urandom_range(9) == 0) walk_dir = -walk_dir;
        walk_pos = (walk_pos + walk_dir + 4) % 4;
        ab = GRAY_WALK[walk_pos];
      end else if (sel < 75) begin
        ab = GRAY_WALK[walk_pos];
      end else if (sel < 85) begin
        walk_pos = (walk_pos + 2) % 4;
        ab = GRAY_WALK[walk_pos];
      end else begin
        ab = 2'($urandom_range(3));
      end
      sel = $urandom_range(99);
      if (sel < 70) begin
        walk_now = walk_now + $urandom_range(60, 1);
      end else if (sel < 85) begin
        walk_now = walk_now + $urandom_range(3000);
      end else if (sel < 92) begin
        walk_now = walk_now + $urandom;
      end else begin
        walk_now = $urandom;
      end
      if ($urandom_range(99) < 80) begin
        bk_n = 1'b1;
        cf_n = 1'b1;
      end else begin
        bk_n = 1'($urandom_range(1));
        cf_n = 1'($urandom_range(1));
      end
      queue_sample(ab[1], ab[0], bk_n, cf_n, walk_now);
    end
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    case (idx)
      CFG_LOCKOUT: nav_lockout = value;
      CFG_DETENT:  nav_detent = value[3:0];
      CFG_PAGES:   nav_pages = value[4:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain;
    while (sample_backlog.size() != 0 || predicted_readouts.size() != 0 || in_tvalid) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic run_phase(logic [15:0] lockout, logic [3:0] detent, logic [4:0] pages,
                           int count, int sidle, int rstall);
    drain();
    write_reg(CFG_LOCKOUT, lockout);
    write_reg(CFG_DETENT, {12'd0, detent});
    write_reg(CFG_PAGES, {11'd0, pages});
    sender_idle_pct = sidle;
    recv_stall_pct = rstall;
    queue_random(count);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: lockout 180, four steps per detent, three pages
    queue_sample(0, 0, 0, 0, 32'd0);        // first item latches, press inside lockout
    queue_sample(0, 1, 0, 1, 32'd179);      // one short of lockout
    queue_sample(1, 1, 0, 0, 32'd180);      // lockout boundary, back wins over confirm
    queue_sample(1, 0, 1, 0, 32'd200);      // press inside lockout
    queue_sample(0, 0, 1, 1, 32'd359);      // fourth step, detent
    queue_sample(0, 0, 1, 0, 32'd360);      // no movement, confirm taken
    queue_sample(1, 0, 1, 1, 32'd361);
    queue_sample(1, 1, 1, 1, 32'd362);
    queue_sample(0, 1, 1, 1, 32'd363);
    queue_sample(0, 0, 1, 0, 32'd540);      // detent and press in one item
    queue_sample(1, 1, 1, 1, 32'd541);      // both lines change
    queue_sample(0, 0, 1, 1, 32'd542);
    queue_sample(0, 0, 0, 1, 32'hFFFF_FFFF);
    queue_sample(0, 0, 1, 0, 32'h0000_00B2); // wrapped gap one short
    queue_sample(0, 0, 1, 0, 32'h0000_00B3); // wrapped gap exactly lockout
    for (int i = 0; i < 8; i++) begin
      queue_sample(GRAY_WALK[(4 - (i % 4)) % 4][1], GRAY_WALK[(4 - (i % 4)) % 4][0],
                   1'b1, 1'b1, 32'h0000_0100 + 32'(i));
    end
    queue_sample(1, 1, 1, 1, 32'h8000_0000);

    run_phase(16'd0, 4'd1, 5'd16, 200, 0, 0);
    run_phase(16'd65535, 4'd8, 5'd1, 150, 66, 0);
    run_phase(16'd50, 4'd0, 5'd0, 150, 0, 66);
    run_phase(16'd10, 4'd3, 5'd31, 150, 20, 20);
    // lowered page count leaves the index beyond it
    run_phase(16'd180, 4'd4, 5'd5, 250, 20, 20);
    run_phase(16'($urandom_range(65535)), 4'd2, 5'd20, 200, 0, 0);
    run_phase(16'd1000, 4'd8, 5'd7, 200, 66, 66);

    drain();
    error_count += predicted_readouts.size();
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ quadrature_page_navigator.f @@
hw/rtl/qpn_pkg.sv
hw/rtl/qpn_step.sv
hw/rtl/quadrature_page_navigator.sv
bench/quadrature_page_navigator_test.sv
